/* hw/rtl/mmd_pkg.sv */
// Shared constants and types for the multichannel min/max decimator.
package mmd_pkg;

   localparam int MAX_CHANNELS   = 8;
   localparam int SAMPLE_BITS    = 16;
   localparam int CHAN_BITS      = $clog2(MAX_CHANNELS);
   localparam int FRAME_BITS     = 20;
   localparam int LEN_BITS       = 16;
   localparam int COUNT_BITS     = 4;
   localparam int CSR_ADDR_BITS  = 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam int REQ_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int REQ_TUSER_BITS = CHAN_BITS;
   localparam int RSP_TDATA_BITS = ((FRAME_BITS + 2 * SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_TUSER_BITS = CHAN_BITS;
   localparam int RSP_PAD_BITS   = RSP_TDATA_BITS - FRAME_BITS - 2 * SAMPLE_BITS;

   localparam logic [LEN_BITS-1:0]   FRAME_LENGTH_RESET  = 16'd256;
   localparam logic [COUNT_BITS-1:0] CHANNEL_COUNT_RESET = 4'd2;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_FRAME_LENGTH  = 1'b0,
      CSR_CHANNEL_COUNT = 1'b1
   } csr_addr_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // Per-channel running state
   typedef struct packed {
      sample_type            high;
      sample_type            low;
      logic [LEN_BITS-1:0]   pos;
      logic [FRAME_BITS-1:0] frame;
   } chan_state_type;

   // One frame summary as delivered on the result channel
   typedef struct packed {
      logic [FRAME_BITS-1:0] frame_index;
      sample_type            peak_high;
      sample_type            peak_low;
      logic                  is_partial;
   } summary_type;

   localparam chan_state_type CHAN_STATE_RESET = '0;

endpackage

/* hw/rtl/mmd_chan_update.sv */
// Per-channel frame update: next running state and the frame summary to emit.
module mmd_chan_update
   import mmd_pkg::*;
(
   input  sample_type            sample,
   input  logic                  flush,
   input  logic [LEN_BITS-1:0]   frame_length,
   input  chan_state_type        cur,
   output chan_state_type        nxt,
   output summary_type           summary,
   output logic                  emit
);

   logic frame_full;

   assign frame_full = (cur.pos >= frame_length);

   // Summary always reflects the frame as it stands before this item
   assign summary.frame_index = cur.frame;
   assign summary.peak_high   = cur.high;
   assign summary.peak_low    = cur.low;
   assign summary.is_partial  = flush;

   always_comb begin
      nxt  = cur;
      emit = 1'b0;
      if (flush) begin
         emit = 1'b1;
         nxt  = CHAN_STATE_RESET;
      end else if (frame_full) begin
         // close the frame and seed the next one with this sample
         emit      = 1'b1;
         nxt.frame = cur.frame + FRAME_BITS'(1);
         nxt.high  = sample;
         nxt.low   = sample;
         nxt.pos   = LEN_BITS'(1);
      end else begin
         if (sample > cur.high) begin
            nxt.high = sample;
         end else if (sample < cur.low) begin
            nxt.low = sample;
         end
         nxt.pos = cur.pos + LEN_BITS'(1);
      end
   end

endmodule

/* hw/rtl/multichannel_min_max_decimator.sv */
// Multichannel min/max peak decimator top level: stream ports, state and pipeline.
//
// Reduces a channel-tagged Q1.15 sample stream to one high/low pair per
// channel for every frame_length samples. An item is taken into an input
// register; as it leaves that register, the channel's state (held in
// flip-flops, one entry per channel) is read, updated and written back while
// any frame summary is loaded into the output register. The block takes one
// item per clock cycle unless a summary is held up by the output register.
// Items that give no summary never wait on the result side; one that does
// waits only while the output register still holds an untaken summary.
// Channels at or above channel_count are ignored.
// A flush (req_tlast, end_of_stream) emits the channel's open frame as partial
// (rsp_tlast) and returns the channel to frame zero with a zero seed.
// Registers: 0 frame_length, 1 channel_count.
module multichannel_min_max_decimator
   import mmd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,  // [15:0] sample_value
   input  logic [REQ_TUSER_BITS-1:0] req_tuser,  // [2:0] channel
   input  logic                      req_tlast,  // end_of_stream
   // result channel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,  // [19:0] frame_index, [35:20] peak_high,
                                                 // [51:36] peak_low, [55:52] zero
   output logic [RSP_TUSER_BITS-1:0] rsp_tuser,  // [2:0] out_channel
   output logic                      rsp_tlast,  // is_partial
   // configuration
   input  logic                      csr_wr_en,
   input  logic [CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // configuration registers
   logic [LEN_BITS-1:0]   frame_length_ff,  frame_length_in;
   logic [COUNT_BITS-1:0] channel_count_ff, channel_count_in;

   // input register
   logic                  in_valid_ff, in_valid_in;
   sample_type            in_sample_ff;
   logic [CHAN_BITS-1:0]  in_chan_ff;
   logic                  in_flush_ff;

   // channel state
   chan_state_type        chan_state_ff [MAX_CHANNELS];

   // output register
   logic                  out_valid_ff, out_valid_in;
   summary_type           out_sum_ff;
   logic [CHAN_BITS-1:0]  out_chan_ff;

   chan_state_type        cur_state;
   chan_state_type        nxt_state;
   summary_type           summary;
   logic                  emit;
   logic                  chan_active;
   logic                  produce;
   logic                  advance;
   logic                  req_xfer;

   always_comb begin
      frame_length_in  = frame_length_ff;
      channel_count_in = channel_count_ff;
      if (csr_wr_en) begin
         unique case (csr_addr_type'(csr_addr))
            CSR_FRAME_LENGTH:  frame_length_in  = csr_wdata[LEN_BITS-1:0];
            CSR_CHANNEL_COUNT: channel_count_in = csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff  <= FRAME_LENGTH_RESET;
         channel_count_ff <= CHANNEL_COUNT_RESET;
      end else begin
         frame_length_ff  <= frame_length_in;
         channel_count_ff <= channel_count_in;
      end
   end

   assign cur_state   = chan_state_ff[in_chan_ff];
   assign chan_active = ({1'b0, in_chan_ff} < channel_count_ff);

   mmd_chan_update u_update (
      .sample       (in_sample_ff),
      .flush        (in_flush_ff),
      .frame_length (frame_length_ff),
      .cur          (cur_state),
      .nxt          (nxt_state),
      .summary      (summary),
      .emit         (emit)
   );

   assign produce = chan_active & emit;
   // the stage moves unless it holds a summary and the output register is blocked
   assign advance = in_valid_ff & (~produce | ~out_valid_ff | rsp_tready);

   assign req_tready = ~in_valid_ff | advance;
   assign req_xfer   = req_tvalid & req_tready;

   assign in_valid_in  = req_xfer | (in_valid_ff & ~advance);
   assign out_valid_in = (advance & produce) | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_sample_ff <= sample_type'(req_tdata[SAMPLE_BITS-1:0]);
         in_chan_ff   <= req_tuser[CHAN_BITS-1:0];
         in_flush_ff  <= req_tlast;
      end
      if (advance & produce) begin
         out_sum_ff  <= summary;
         out_chan_ff <= in_chan_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            chan_state_ff[i] <= CHAN_STATE_RESET;
         end
      end else if (advance & chan_active) begin
         chan_state_ff[in_chan_ff] <= nxt_state;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}}, out_sum_ff.peak_low, out_sum_ff.peak_high,
                        out_sum_ff.frame_index};
   assign rsp_tuser  = out_chan_ff;
   assign rsp_tlast  = out_sum_ff.is_partial;

`ifndef SYNTHESIS
   // input side only stalls behind a held item that is itself blocked by the output
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input stalled without a blocked summary");

   // running high never drops below running low, so neither does a summary
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_sum_ff.peak_high >= out_sum_ff.peak_low))
      else $error("summary peak_high below peak_low");

   // a flush leaves the channel at frame zero with no samples
   assert property (@(posedge clock) disable iff (reset)
      (advance && chan_active && in_flush_ff) |=>
         (chan_state_ff[$past(in_chan_ff)] == CHAN_STATE_RESET))
      else $error("channel not cleared after flush");
`endif

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the multichannel min/max decimator: directed table, then random stream.
`timescale 1ns / 100ps

module testbench
   import mmd_pkg::*;
();

   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SEG_ITEMS      = 100;
   localparam int NUM_SEGS       = 6;

   typedef enum logic [1:0] {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} check_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0]  chan;
      logic [FRAME_BITS-1:0] frame;
      sample_type            high;
      sample_type            low;
      logic                  partial;
   } frame_sum_type;

   typedef struct packed {
      row_kind_type         kind;
      csr_addr_type         reg_sel;
      logic [15:0]          reg_val;
      sample_type           smp;
      logic [CHAN_BITS-1:0] chan;
      logic                 eos;
      check_type            chk;
      frame_sum_type        want;
   } stim_row_type;

   localparam frame_sum_type NO_SUM = '0;

   // CSR rows are applied only once the block has drained.
   localparam stim_row_type DIRECTED [30] = '{
      // empty flush after reset reports the zero seed
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh0000, 3'd0, 1'b1, CHK_TYPED,
        '{3'd0, 20'd0, 16'sh0000, 16'sh0000, 1'b1}},
      // channels at or above channel_count are dropped
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh7FFF, 3'd2, 1'b0, CHK_NONE, NO_SUM},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh0000, 3'd7, 1'b1, CHK_NONE, NO_SUM},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh8000, 3'd1, 1'b0, CHK_MODEL, NO_SUM},
      '{ROW_CSR,  CSR_FRAME_LENGTH, 16'd2, 16'sh0000, 3'd0, 1'b0, CHK_NONE, NO_SUM},
      '{ROW_CSR,  CSR_CHANNEL_COUNT, 16'd8, 16'sh0000, 3'd0, 1'b0, CHK_NONE, NO_SUM},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh7FFF, 3'd7, 1'b0, CHK_MODEL, NO_SUM},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh8000, 3'd7, 1'b0, CHK_MODEL, NO_SUM},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh0005, 3'd7, 1'b0, CHK_TYPED,
        '{3'd7, 20'd0, 16'sh7FFF, 16'sh8000, 1'b0}},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'shFFFF, 3'd7, 1'b0, CHK_MODEL, NO_SUM},
      // flush of an exactly full frame
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh1234, 3'd7, 1'b1, CHK_TYPED,
        '{3'd7, 20'd1, 16'sh0005, 16'shFFFF, 1'b1}},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh0000, 3'd7, 1'b1, CHK_TYPED,
        '{3'd7, 20'd0, 16'sh0000, 16'sh0000, 1'b1}},
      '{ROW_CSR,  CSR_FRAME_LENGTH, 16'd1, 16'sh0000, 3'd0, 1'b0, CHK_NONE, NO_SUM},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh0064, 3'd0, 1'b0, CHK_MODEL, NO_SUM},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'shFF9C, 3'd0, 1'b0, CHK_TYPED,
        '{3'd0, 20'd0, 16'sh0064, 16'sh0000, 1'b0}},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh0007, 3'd0, 1'b0, CHK_TYPED,
        '{3'd0, 20'd1, 16'shFF9C, 16'shFF9C, 1'b0}},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh0003, 3'd1, 1'b0, CHK_MODEL, NO_SUM},
      '{ROW_CSR,  CSR_FRAME_LENGTH, 16'hFFFF, 16'sh0000, 3'd0, 1'b0, CHK_NONE, NO_SUM},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh1234, 3'd2, 1'b0, CHK_MODEL, NO_SUM},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'shF830, 3'd2, 1'b0, CHK_MODEL, NO_SUM},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh4000, 3'd2, 1'b0, CHK_MODEL, NO_SUM},
      // shrink frame_length below channel 2's position: next sample closes
      '{ROW_CSR,  CSR_FRAME_LENGTH, 16'd2, 16'sh0000, 3'd0, 1'b0, CHK_NONE, NO_SUM},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh0AAA, 3'd2, 1'b0, CHK_MODEL, NO_SUM},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh5555, 3'd0, 1'b1, CHK_MODEL, NO_SUM},
      '{ROW_CSR,  CSR_CHANNEL_COUNT, 16'd1, 16'sh0000, 3'd0, 1'b0, CHK_NONE, NO_SUM},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh2222, 3'd1, 1'b0, CHK_NONE, NO_SUM},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh8000, 3'd0, 1'b0, CHK_MODEL, NO_SUM},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh7FFF, 3'd0, 1'b0, CHK_MODEL, NO_SUM},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh0000, 3'd0, 1'b0, CHK_MODEL, NO_SUM},
      '{ROW_ITEM, CSR_FRAME_LENGTH, 16'd0, 16'sh0000, 3'd0, 1'b1, CHK_MODEL, NO_SUM}
   };

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata;
   logic [REQ_TUSER_BITS-1:0] req_tuser;
   logic                      req_tlast;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic [RSP_TUSER_BITS-1:0] rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_wr_en;
   logic [CSR_ADDR_BITS-1:0]  csr_addr;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   // predictor state and its copy of the registers
   sample_type            peak_hi   [MAX_CHANNELS];
   sample_type            peak_lo   [MAX_CHANNELS];
   logic [LEN_BITS-1:0]   frame_pos [MAX_CHANNELS];
   logic [FRAME_BITS-1:0] frame_num [MAX_CHANNELS];
   logic [LEN_BITS-1:0]   cfg_frame_len;
   logic [COUNT_BITS-1:0] cfg_chan_count;

   frame_sum_type pending_summaries[$];
   check_type     item_chk;
   frame_sum_type item_want;
   int            fail_count;
   int            quiet_cycles;
   int            src_idle_pct;
   int            sink_idle_pct;

   multichannel_min_max_decimator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Folds one sample or flush into the per-channel peaks; returns 1 with the
   // closed frame's summary when the item emits one.
   function automatic bit fold_item(input sample_type s, input logic [CHAN_BITS-1:0] ch,
                                    input logic eos, output frame_sum_type sum);
      bit hit;
      hit = 1'b0;
      sum = '0;
      if ({1'b0, ch} >= cfg_chan_count)
         return 1'b0;
      if (eos) begin
         sum = '{ch, frame_num[ch], peak_hi[ch], peak_lo[ch], 1'b1};
         peak_hi[ch]   = '0;
         peak_lo[ch]   = '0;
         frame_pos[ch] = '0;
         frame_num[ch] = '0;
         return 1'b1;
      end
      if (frame_pos[ch] >= cfg_frame_len) begin
         sum = '{ch, frame_num[ch], peak_hi[ch], peak_lo[ch], 1'b0};
         hit = 1'b1;
         frame_num[ch] = frame_num[ch] + FRAME_BITS'(1);
         peak_hi[ch]   = s;
         peak_lo[ch]   = s;
         frame_pos[ch] = '0;
      end else if (s > peak_hi[ch]) begin
         peak_hi[ch] = s;
      end else if (s < peak_lo[ch]) begin
         peak_lo[ch] = s;
      end
      frame_pos[ch] = frame_pos[ch] + LEN_BITS'(1);
      return hit;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic sample_type rand_sample();
      case ($urandom_range(15))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic send_item(input sample_type s, input logic [CHAN_BITS-1:0] ch,
                            input logic eos, input check_type chk, input frame_sum_type want);
      logic taken;
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      item_chk   = chk;
      item_want  = want;
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tuser  <= ch;
      req_tlast  <= eos;
      // ready is stable from the falling edge up to the transfer edge
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Sender holds off until every expected summary is out, plus pipeline depth
   // for items that produce none.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_summaries.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_addr_type sel, input logic [CSR_DATA_BITS-1:0] val);
      csr_wr_en <= 1'b1;
      csr_addr  <= sel;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (sel == CSR_FRAME_LENGTH)
         cfg_frame_len = val;
      else
         cfg_chan_count = val[COUNT_BITS-1:0];
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= sink_idle_pct);
   end

   // Transfers are sampled on the falling edge, ahead of the edge that takes them.
   always @(negedge clock) begin : monitor
      frame_sum_type sum;
      frame_sum_type want;
      bit            hit;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            hit = fold_item($signed(req_tdata[SAMPLE_BITS-1:0]), req_tuser, req_tlast, sum);
            case (item_chk)
               CHK_TYPED: pending_summaries.push_back(item_want);
               CHK_MODEL: if (hit) pending_summaries.push_back(sum);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_summaries.size() == 0) begin
               $error("unexpected frame summary on channel %0d", rsp_tuser);
               fail_count++;
            end else begin
               want = pending_summaries.pop_front();
               check_field("out_channel", want.chan, rsp_tuser);
               check_field("frame_index", want.frame, rsp_tdata[19:0]);
               check_field("peak_high", want.high, $signed(rsp_tdata[35:20]));
               check_field("peak_low", want.low, $signed(rsp_tdata[51:36]));
               check_field("is_partial", want.partial, rsp_tlast);
               check_field("tdata_pad", 0, rsp_tdata[55:52]);
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int                     done;
      int                     flush_pct;
      logic [LEN_BITS-1:0]    len;
      logic [COUNT_BITS-1:0]  cnt;
      logic [CSR_DATA_BITS-1:0] cnt_word;
      logic [CHAN_BITS-1:0]   ch;
      logic                   eos;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      req_tlast     = 1'b0;
      rsp_tready    = 1'b0;
      csr_wr_en     = 1'b0;
      csr_addr      = CSR_FRAME_LENGTH;
      csr_wdata     = '0;
      item_chk      = CHK_NONE;
      item_want     = NO_SUM;
      fail_count    = 0;
      quiet_cycles  = 0;
      src_idle_pct  = 24;
      sink_idle_pct = 75;
      cfg_frame_len  = FRAME_LENGTH_RESET;
      cfg_chan_count = CHANNEL_COUNT_RESET;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         peak_hi[c]   = '0;
         peak_lo[c]   = '0;
         frame_pos[c] = '0;
         frame_num[c] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_CSR) begin
            wait_drained();
            write_csr(DIRECTED[i].reg_sel, DIRECTED[i].reg_val);
         end else begin
            send_item(DIRECTED[i].smp, DIRECTED[i].chan, DIRECTED[i].eos,
                      DIRECTED[i].chk, DIRECTED[i].want);
         end
      end

      for (int seg = 0; seg < NUM_SEGS; seg++) begin
         if (seg == 2) begin
            src_idle_pct  = 75;
            sink_idle_pct = 24;
         end
         if (seg == 4) begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
         end
         case (seg)
            0: begin
               len = LEN_BITS'($urandom_range(4, 1));
               cnt = 4'd8;
            end
            1: begin
               len = 16'hFFFF;
               cnt = COUNT_BITS'($urandom_range(8, 1));
            end
            2: begin
               len = LEN_BITS'($urandom_range(20, 5));
               cnt = 4'd1;
            end
            3: begin
               len = 16'd1;
               cnt = COUNT_BITS'($urandom_range(7, 2));
            end
            4: begin
               len = LEN_BITS'($urandom_range(8, 1));
               cnt = 4'd8;
            end
            default: begin
               len = LEN_BITS'($urandom_range(16, 1));
               cnt = COUNT_BITS'($urandom_range(8, 1));
            end
         endcase
         wait_drained();
         write_csr(CSR_FRAME_LENGTH, len);
         // upper bits of the count write are don't-care
         cnt_word = CSR_DATA_BITS'($urandom);
         cnt_word[COUNT_BITS-1:0] = cnt;
         write_csr(CSR_CHANNEL_COUNT, cnt_word);
         flush_pct = (len > 16'd1000) ? 12 : 4;
         done = 0;
         while (done < SEG_ITEMS) begin
            if (seg == 3 && done == SEG_ITEMS / 2)
               wait_drained();
            if (cfg_chan_count < MAX_CHANNELS && $urandom_range(99) < 8)
               ch = CHAN_BITS'($urandom_range(MAX_CHANNELS - 1, cfg_chan_count));
            else
               ch = CHAN_BITS'($urandom_range(cfg_chan_count - 1, 0));
            eos = ($urandom_range(99) < flush_pct);
            send_item(rand_sample(), ch, eos, CHK_MODEL, NO_SUM);
            if ({1'b0, ch} < cfg_chan_count)
               done++;
         end
      end

      wait_drained();
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/mmd_pkg.sv
hw/rtl/mmd_chan_update.sv
hw/rtl/multichannel_min_max_decimator.sv
bench/testbench.sv
